// ===== src/integer_literal_parser_macros.svh =====
// Assertion macros for the integer literal parser.
// Clocked on clk_i and disabled while rst_ni is low; no other dependencies.
`ifndef INTEGER_LITERAL_PARSER_MACROS_SVH
`define INTEGER_LITERAL_PARSER_MACROS_SVH

`ifndef SYNTH
`define ILP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("integer_literal_parser: assertion failed");
`define ILP_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define ILP_ASSERT(lbl, prop)
`define ILP_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

// ===== src/ilp_pkg.sv =====
// Shared types and character codes for the integer literal parser.
// No dependencies.
package ilp_pkg;

  localparam int unsigned CH_W  = 16;
  localparam int unsigned RES_W = 64;

  localparam logic [CH_W-1:0] CH_MINUS = 16'h002D;
  localparam logic [CH_W-1:0] CH_0     = 16'h0030;
  localparam logic [CH_W-1:0] CH_1     = 16'h0031;
  localparam logic [CH_W-1:0] CH_7     = 16'h0037;
  localparam logic [CH_W-1:0] CH_9     = 16'h0039;
  localparam logic [CH_W-1:0] CH_UA    = 16'h0041;
  localparam logic [CH_W-1:0] CH_UF    = 16'h0046;
  localparam logic [CH_W-1:0] CH_UU    = 16'h0055;
  localparam logic [CH_W-1:0] CH_LA    = 16'h0061;
  localparam logic [CH_W-1:0] CH_LB    = 16'h0062;
  localparam logic [CH_W-1:0] CH_LF    = 16'h0066;
  localparam logic [CH_W-1:0] CH_LU    = 16'h0075;
  localparam logic [CH_W-1:0] CH_LX    = 16'h0078;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_DEC   = 3'd1,
    PH_ZERO  = 3'd2,
    PH_HEX   = 3'd3,
    PH_OCT   = 3'd4,
    PH_BIN   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ACC_HOLD  = 3'd0,
    ACC_FIRST = 3'd1,
    ACC_DEC   = 3'd2,
    ACC_HEX   = 3'd3,
    ACC_OCT   = 3'd4,
    ACC_BIN   = 3'd5
  } acc_op_e;

  typedef struct packed {
    phase_e phase;
    logic   neg;
    logic   uns;
    logic   err;
    logic   fin;
  } parse_state_t;

  localparam parse_state_t ST_RESET = '{
    phase: PH_START, neg: 1'b0, uns: 1'b0, err: 1'b0, fin: 1'b0
  };

endpackage

// ===== src/ilp_if.sv =====
// Valid/ready channel interfaces for the integer literal parser.
// Depends on ilp_pkg for field widths.
interface ilp_in_if import ilp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ilp_out_if import ilp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result_value;
  logic             is_unsigned;
  logic             parse_error;

  modport source (output valid, output result_value, output is_unsigned,
                  output parse_error, input ready);
  modport sink   (input valid, input result_value, input is_unsigned,
                  input parse_error, output ready);
endinterface

// ===== src/integer_literal_parser.sv =====
// Integer literal parser top level: input stage, parse state, result register.
// Depends on ilp_pkg, ilp_if, ilp_step and integer_literal_parser_macros.svh.
//
//   channel  dir  beat payload                               per literal
//   in_i     in   ch[15:0], last                             one per character
//   out_o    out  result_value[63:0], is_unsigned, parse_error  one, on last
//
// One character per cycle unless a held result stalls a last beat: a beat is
// registered, then stepped through ilp_step as it advances; a last beat also
// loads the result register, which holds the result valid until it is taken.
// Reset clears the parse state and all valid flags; no clearing pass.
// A held result stalls only a beat that carries last; other beats keep flowing.
`include "integer_literal_parser_macros.svh"

module integer_literal_parser import ilp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ilp_in_if.sink           in_i,
  ilp_out_if.source        out_o
);

  logic                   in_vld_q;
  logic [CH_W-1:0]        ch_q;
  logic                   last_q;
  parse_state_t           st_q;
  parse_state_t           st_d;
  logic [VALUE_WIDTH-1:0] acc_q;
  logic [VALUE_WIDTH-1:0] acc_d;
  logic                   out_vld_q;
  logic [RES_W-1:0]       res_value_q;
  logic                   res_uns_q;
  logic                   res_err_q;
  logic                   advance;

  assign advance    = in_vld_q && (!last_q || !out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  ilp_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .st_i  (st_q),
    .acc_i (acc_q),
    .ch_i  (ch_q),
    .st_o  (st_d),
    .acc_o (acc_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q   <= in_i.ch;
      last_q <= in_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_RESET;
      acc_q <= '0;
    end else if (advance) begin
      if (last_q) begin
        st_q  <= ST_RESET;
        acc_q <= '0;
      end else begin
        st_q  <= st_d;
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && last_q) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      res_err_q <= st_d.err;
      if (st_d.err) begin
        res_value_q <= '0;
        res_uns_q   <= 1'b0;
      end else begin
        res_value_q <= RES_W'(acc_d);
        res_uns_q   <= st_d.uns;
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.result_value = res_value_q;
  assign out_o.is_unsigned  = res_uns_q;
  assign out_o.parse_error  = res_err_q;

  `ILP_ASSERT_MSG(a_err_clears_value, out_o.valid && out_o.parse_error |-> out_o.result_value == '0 && !out_o.is_unsigned, "error result carries a value")
  `ILP_ASSERT(a_upper_bits_zero, out_o.valid |-> (out_o.result_value >> VALUE_WIDTH) == '0)
  `ILP_ASSERT(a_restart_after_last, advance && last_q |=> st_q == ST_RESET && acc_q == '0)
  `ILP_ASSERT_MSG(a_stalled_beat_held, in_vld_q && !advance |=> in_vld_q && $stable(ch_q), "stalled beat dropped")

endmodule

// ===== src/ilp_step.sv =====
// Next-state logic for one character: phase update and accumulator step.
// Depends on ilp_pkg. The accumulator carries the sign, so no final negate.
module ilp_step import ilp_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  parse_state_t           st_i,
  input  logic [VALUE_WIDTH-1:0] acc_i,
  input  logic [CH_W-1:0]        ch_i,
  output parse_state_t           st_o,
  output logic [VALUE_WIDTH-1:0] acc_o
);

  acc_op_e                op;
  logic [3:0]             dig;
  logic [VALUE_WIDTH-1:0] dig_ext;
  logic [VALUE_WIDTH-1:0] acc_x8;
  logic [VALUE_WIDTH-1:0] acc_x2;
  logic [VALUE_WIDTH-1:0] scaled;
  logic                   is_dec;
  logic                   is_oct;
  logic                   is_nz_dec;
  logic                   is_nz_oct;
  logic                   is_bin;
  logic                   is_hex_lc;
  logic                   is_hex_uc;
  logic                   is_sfx;

  assign is_dec    = (ch_i >= CH_0) && (ch_i <= CH_9);
  assign is_nz_dec = (ch_i >= CH_1) && (ch_i <= CH_9);
  assign is_oct    = (ch_i >= CH_0) && (ch_i <= CH_7);
  assign is_nz_oct = (ch_i >= CH_1) && (ch_i <= CH_7);
  assign is_bin    = (ch_i == CH_0) || (ch_i == CH_1);
  assign is_hex_lc = (ch_i >= CH_LA) && (ch_i <= CH_LF);
  assign is_hex_uc = (ch_i >= CH_UA) && (ch_i <= CH_UF);
  assign is_sfx    = (ch_i == CH_LU) || (ch_i == CH_UU);

  always_comb begin
    st_o = st_i;
    op   = ACC_HOLD;
    dig  = ch_i[3:0];
    if (!st_i.err && !st_i.fin) begin
      unique case (st_i.phase)
        PH_START: begin
          if (ch_i == CH_MINUS) begin
            st_o.neg = 1'b1;
          end else if (is_nz_dec) begin
            op         = ACC_FIRST;
            st_o.phase = PH_DEC;
          end else if (ch_i == CH_0) begin
            st_o.phase = PH_ZERO;
          end else begin
            st_o.err = 1'b1;
          end
        end
        PH_DEC: begin
          if (is_dec) begin
            op = ACC_DEC;
          end else if (is_sfx) begin
            st_o.uns = 1'b1;
            st_o.fin = 1'b1;
          end else begin
            st_o.err = 1'b1;
          end
        end
        PH_ZERO: begin
          if (is_nz_oct) begin
            op         = ACC_FIRST;
            st_o.phase = PH_OCT;
          end else if (ch_i == CH_LX) begin
            st_o.phase = PH_HEX;
          end else if (ch_i == CH_LB) begin
            st_o.uns   = 1'b1;
            st_o.phase = PH_BIN;
          end else begin
            st_o.err = 1'b1;
          end
        end
        PH_HEX: begin
          if (is_dec) begin
            op = ACC_HEX;
          end else if (is_hex_lc || is_hex_uc) begin
            op  = ACC_HEX;
            dig = ch_i[3:0] + 4'd9;
          end else if (is_sfx) begin
            st_o.uns = 1'b1;
            st_o.fin = 1'b1;
          end else begin
            st_o.err = 1'b1;
          end
        end
        PH_OCT: begin
          if (is_oct) begin
            op = ACC_OCT;
          end else if (is_sfx) begin
            st_o.uns = 1'b1;
            st_o.fin = 1'b1;
          end else begin
            st_o.err = 1'b1;
          end
        end
        PH_BIN: begin
          if (is_bin) begin
            op = ACC_BIN;
          end else begin
            st_o.err = 1'b1;
          end
        end
        default: begin
          st_o.err = 1'b1;
        end
      endcase
    end
  end

  assign acc_x8  = acc_i << 3;
  assign acc_x2  = acc_i << 1;
  assign dig_ext = VALUE_WIDTH'(dig);

  always_comb begin
    unique case (op)
      ACC_DEC: scaled = acc_x8 + acc_x2;
      ACC_HEX: scaled = acc_i << 4;
      ACC_OCT: scaled = acc_x8;
      ACC_BIN: scaled = acc_x2;
      default: scaled = '0;
    endcase
  end

  always_comb begin
    if (op == ACC_HOLD) begin
      acc_o = acc_i;
    end else if (st_i.neg) begin
      acc_o = scaled - dig_ext;
    end else begin
      acc_o = scaled + dig_ext;
    end
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for integer_literal_parser: literal text in, parsed values out.
// Depends on ilp_pkg and the ilp_in_if / ilp_out_if channel interfaces of the RTL.
// An internal scanner predicts every literal; directed rows carry a few fixed answers.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ilp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_CHARS = 860;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 20;

  localparam logic [CH_W-1:0] CH_UB  = 16'h0042;
  localparam logic [CH_W-1:0] CH_UX  = 16'h0058;
  localparam logic [CH_W-1:0] CH_NUL = 16'h0000;
  localparam logic [CH_W-1:0] CH_TOP = 16'hFFFF;

  typedef struct packed {
    logic [RES_W-1:0] value;
    logic             uns;
    logic             err;
  } literal_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    logic            known;
    literal_t        want;
  } char_row_t;

  typedef struct packed {
    phase_e           phase;
    logic [RES_W-1:0] acc;
    logic             neg;
    logic             uns;
    logic             err;
    logic             fin;
  } scanner_t;

  localparam literal_t NO_RES = '{'0, 1'b0, 1'b0};
  localparam literal_t ZERO_S = '{64'd0, 1'b0, 1'b0};
  localparam literal_t ZERO_U = '{64'd0, 1'b1, 1'b0};
  localparam literal_t NINE_U = '{64'd9, 1'b1, 1'b0};
  localparam literal_t BAD    = '{64'd0, 1'b0, 1'b1};

  localparam scanner_t SCAN_IDLE = '{PH_START, '0, 1'b0, 1'b0, 1'b0, 1'b0};

  localparam int N_ROWS = 28;
  localparam char_row_t CHAR_TABLE [N_ROWS] = '{
    '{CH_0,     1'b1, 1'b1, ZERO_S},
    '{CH_MINUS, 1'b1, 1'b1, ZERO_S},
    '{CH_0,     1'b0, 1'b0, NO_RES},
    '{CH_LB,    1'b1, 1'b1, ZERO_U},
    '{CH_0,     1'b0, 1'b0, NO_RES},
    '{CH_LX,    1'b1, 1'b1, ZERO_S},
    '{CH_0,     1'b0, 1'b0, NO_RES},
    '{CH_0,     1'b1, 1'b1, BAD},
    '{CH_0,     1'b0, 1'b0, NO_RES},
    '{CH_LU,    1'b1, 1'b1, BAD},
    '{CH_0,     1'b0, 1'b0, NO_RES},
    '{CH_UX,    1'b1, 1'b1, BAD},
    '{CH_1,     1'b0, 1'b0, NO_RES},
    '{CH_MINUS, 1'b1, 1'b1, BAD},
    '{CH_9,     1'b0, 1'b0, NO_RES},
    '{CH_UU,    1'b0, 1'b0, NO_RES},
    '{CH_TOP,   1'b1, 1'b1, NINE_U},
    '{CH_NUL,   1'b1, 1'b1, BAD},
    '{CH_MINUS, 1'b0, 1'b0, NO_RES},
    '{CH_0,     1'b0, 1'b0, NO_RES},
    '{CH_LX,    1'b0, 1'b0, NO_RES},
    '{CH_UF,    1'b0, 1'b0, NO_RES},
    '{CH_LF,    1'b1, 1'b0, NO_RES},
    '{CH_0,     1'b0, 1'b0, NO_RES},
    '{CH_7,     1'b1, 1'b0, NO_RES},
    '{CH_0,     1'b0, 1'b0, NO_RES},
    '{CH_LB,    1'b0, 1'b0, NO_RES},
    '{CH_LU,    1'b1, 1'b1, BAD}
  };

  logic clk_i;
  logic rst_ni;

  ilp_in_if  char_bus ();
  ilp_out_if value_bus ();

  integer_literal_parser u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_bus),
    .out_o  (value_bus)
  );

  scanner_t    scan = SCAN_IDLE;
  literal_t    literals_due[$];
  int unsigned fail_count  = 0;
  int unsigned chars_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;
  bit          hold_wanted = 1'b0;

  function automatic void flag_failure(string what);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%0t ns: %s", $time, what);
  endfunction

  function automatic void scan_char(logic [CH_W-1:0] c);
    case (scan.phase)
      PH_START: begin
        if (c == CH_MINUS) scan.neg = 1'b1;
        else if (c >= CH_1 && c <= CH_9) begin
          scan.acc   = RES_W'(c - CH_0);
          scan.phase = PH_DEC;
        end else if (c == CH_0) scan.phase = PH_ZERO;
        else scan.err = 1'b1;
      end
      PH_DEC: begin
        if (c >= CH_0 && c <= CH_9) scan.acc = scan.acc * 64'd10 + RES_W'(c - CH_0);
        else if (c == CH_LU || c == CH_UU) begin
          scan.uns = 1'b1;
          scan.fin = 1'b1;
        end else scan.err = 1'b1;
      end
      PH_ZERO: begin
        if (c >= CH_1 && c <= CH_7) begin
          scan.acc   = RES_W'(c - CH_0);
          scan.phase = PH_OCT;
        end else if (c == CH_LX) scan.phase = PH_HEX;
        else if (c == CH_LB) begin
          scan.uns   = 1'b1;
          scan.phase = PH_BIN;
        end else scan.err = 1'b1;
      end
      PH_HEX: begin
        if (c >= CH_0 && c <= CH_9) scan.acc = {scan.acc[RES_W-5:0], 4'(c - CH_0)};
        else if (c >= CH_LA && c <= CH_LF) scan.acc = {scan.acc[RES_W-5:0], 4'(c - CH_LA + 10)};
        else if (c >= CH_UA && c <= CH_UF) scan.acc = {scan.acc[RES_W-5:0], 4'(c - CH_UA + 10)};
        else if (c == CH_LU || c == CH_UU) begin
          scan.uns = 1'b1;
          scan.fin = 1'b1;
        end else scan.err = 1'b1;
      end
      PH_OCT: begin
        if (c >= CH_0 && c <= CH_7) scan.acc = {scan.acc[RES_W-4:0], 3'(c - CH_0)};
        else if (c == CH_LU || c == CH_UU) begin
          scan.uns = 1'b1;
          scan.fin = 1'b1;
        end else scan.err = 1'b1;
      end
      PH_BIN: begin
        if (c == CH_0 || c == CH_1) scan.acc = {scan.acc[RES_W-2:0], c[0]};
        else scan.err = 1'b1;
      end
      default: scan.err = 1'b1;
    endcase
  endfunction

  function automatic void take_char(logic [CH_W-1:0] c, logic last, logic known,
                                    literal_t want);
    literal_t got;
    if (!scan.err && !scan.fin) scan_char(c);
    if (last) begin
      if (scan.err) got = BAD;
      else got = '{scan.neg ? -scan.acc : scan.acc, scan.uns, 1'b0};
      literals_due.push_back(known ? want : got);
      scan = SCAN_IDLE;
    end
  endfunction

  function automatic logic [CH_W-1:0] stray_char();
    logic [CH_W-1:0] c;
    case ($urandom_range(0, 4))
      0: c = CH_W'($urandom);
      1: c = CH_W'($urandom_range(32, 126));
      2: c = CH_MINUS;
      3: c = $urandom_range(0, 1) ? CH_UX : CH_UB;
      default: c = $urandom_range(0, 1) ? CH_LU : CH_0;
    endcase
    return c;
  endfunction

  task automatic send_char(logic [CH_W-1:0] c, logic last, logic known, literal_t want);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) begin
        @(negedge clk_i);
        char_bus.valid <= 1'b0;
      end
      burst_left = $urandom_range(0, 7) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 10);
    end
    @(negedge clk_i);
    char_bus.valid <= 1'b1;
    char_bus.ch    <= c;
    char_bus.last  <= last;
    do @(posedge clk_i); while (!char_bus.ready);
    take_char(c, last, known, want);
    chars_sent++;
    burst_left--;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    char_bus.valid <= 1'b0;
    while (literals_due.size() != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic send_random_literal();
    logic [CH_W-1:0] text[$];
    int form;
    int ndig;
    int d;
    int pos;
    if ($urandom_range(0, 14) == 0) begin
      repeat ($urandom_range(1, 4)) text.push_back(stray_char());
    end else begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) text.push_back(CH_MINUS);
      form = $urandom_range(0, 4);
      ndig = $urandom_range(0, 7) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 6);
      case (form)
        0: begin
          text.push_back(CH_W'(CH_1 + $urandom_range(0, 8)));
          repeat (ndig) text.push_back(CH_W'(CH_0 + $urandom_range(0, 9)));
        end
        1: begin
          text.push_back(CH_0);
          text.push_back(CH_LX);
          repeat (ndig) begin
            d = $urandom_range(0, 15);
            if (d < 10) text.push_back(CH_W'(CH_0 + d));
            else text.push_back(CH_W'(($urandom_range(0, 1) ? CH_UA : CH_LA) + d - 10));
          end
        end
        2: begin
          text.push_back(CH_0);
          text.push_back(CH_W'(CH_1 + $urandom_range(0, 6)));
          repeat (ndig) text.push_back(CH_W'(CH_0 + $urandom_range(0, 7)));
        end
        3: begin
          text.push_back(CH_0);
          text.push_back(CH_LB);
          repeat (ndig) text.push_back(CH_W'(CH_0 + $urandom_range(0, 1)));
        end
        default: text.push_back(CH_0);
      endcase
      if ((form != 3 || $urandom_range(0, 3) == 0) && $urandom_range(0, 2) == 0) begin
        text.push_back($urandom_range(0, 1) ? CH_LU : CH_UU);
        repeat ($urandom_range(0, 3)) text.push_back(stray_char());
      end
      if ($urandom_range(0, 5) == 0) begin
        pos = $urandom_range(0, text.size() - 1);
        text[pos] = stray_char();
      end
    end
    foreach (text[i]) send_char(text[i], i == text.size() - 1, 1'b0, NO_RES);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int mode;
    int span;
    int odds;
    bit held;
    held = 1'b0;
    value_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_wanted && !held) begin
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          value_bus.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 120);
      odds = $urandom_range(1, 9);
      for (int n = 0; n < span; n++) begin
        @(negedge clk_i);
        case (mode)
          0: value_bus.ready <= 1'b1;
          1: value_bus.ready <= $urandom_range(1, 10) <= odds;
          default: value_bus.ready <= (n % (odds + 1)) != 0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    literal_t want;
    if (rst_ni && value_bus.valid && value_bus.ready) begin
      if (literals_due.size() == 0) begin
        flag_failure($sformatf("result %h uns=%b err=%b with no literal pending",
                               value_bus.result_value, value_bus.is_unsigned,
                               value_bus.parse_error));
      end else begin
        want = literals_due.pop_front();
        if (value_bus.result_value !== want.value || value_bus.is_unsigned !== want.uns ||
            value_bus.parse_error !== want.err)
          flag_failure($sformatf("expected %h uns=%b err=%b, got %h uns=%b err=%b",
                                 want.value, want.uns, want.err, value_bus.result_value,
                                 value_bus.is_unsigned, value_bus.parse_error));
      end
    end
  end

  initial begin
    bit drained_mid;
    drained_mid    = 1'b0;
    rst_ni         = 1'b0;
    char_bus.valid = 1'b0;
    char_bus.ch    = '0;
    char_bus.last  = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_ROWS; i++)
      send_char(CHAR_TABLE[i].ch, CHAR_TABLE[i].last, CHAR_TABLE[i].known, CHAR_TABLE[i].want);
    drain_results();

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      if (!hold_wanted && chars_sent >= 150) hold_wanted = 1'b1;
      if (!drained_mid && chars_sent >= RANDOM_CHARS / 2) begin
        drain_results();
        drained_mid = 1'b1;
      end
      send_random_literal();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (literals_due.size() != 0) flag_failure("literals left without a result");
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
